// ===== design/ekv_pkg.sv =====
// ============================================================================
// ekv_pkg : shared types and constants for the expiring key/value table
// Command and result codes, queue entry layout, engine states.
// ============================================================================
package ekv_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_UPDATE = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_BAD5   = 3'd5,
        CMD_BAD6   = 3'd6,
        CMD_BAD7   = 3'd7
    } t_cmd;

    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_MATURED = 2'd1;
    localparam logic [1:0] KIND_REMOVED = 2'd2;
    localparam logic [1:0] KIND_REPLACE = 2'd3;

    localparam logic [0:0] REG_VALUES = 1'b0;
    localparam logic [0:0] REG_NOTIFY = 1'b1;

    // request handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        logic [31:0] value;
        logic [23:0] delay;
    } t_req;

    // one result
    typedef struct packed {
        logic [1:0]  kind;
        logic        found;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] mature;
        logic [4:0]  count;
        logic        full;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_APPLY,
        ST_REPLY
    } t_state;

endpackage

// ===== design/ekv_front.sv =====
// ============================================================================
// ekv_front : request intake queue
// Accepts requests, normalizes unknown commands and buffers them.
// ============================================================================
module ekv_front
    import ekv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_req        i_req,
    output logic        o_valid,
    output t_req        o_req,
    input  logic        i_take
);
    t_req r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic r_rd, r_wr;
    logic do_push;
    t_req req_norm;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];
    assign do_push = i_push && !o_full;

    // count entries
    always_comb begin
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, i_take && o_valid};
    end

    // unknown commands keep no key
    always_comb begin
        req_norm = i_req;
        if (i_req.cmd > CMD_LOOKUP) req_norm.key = 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wr <= !r_wr;
            if (i_take && o_valid) r_rd <= !r_rd;
        end
    end

    // store request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= req_norm;
        end
    end
endmodule

// ===== design/ekv_back.sv =====
// ============================================================================
// ekv_back : table engine
// Scans slots one per cycle for key match, free slot or earliest maturity.
// ============================================================================
module ekv_back
    import ekv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_values_held,
    input  logic        i_notify,
    input  logic        i_valid,
    input  t_req        i_req,
    output logic        o_take,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_res_take
);
    localparam int IW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] r_valid;
    logic [31:0] r_key [CAPACITY];
    logic [31:0] r_val [CAPACITY];
    logic [31:0] r_mat [CAPACITY];
    logic [31:0] r_now;
    logic [4:0]  r_count;

    t_state r_state, n_state;
    t_req   r_req;
    logic [IW:0] r_idx;
    logic        r_hit, r_free_ok, r_best_ok;
    logic [IW-1:0] r_hit_i, r_free_i, r_best_i;
    logic [31:0] r_best_t, r_best_k;
    logic        r_out_v, n_out_v;
    t_res        r_out, n_out;

    logic [IW-1:0] idx;
    logic [31:0]   cur_t, age, expire;
    logic          matured, better, emit_go, scan_end;
    logic [31:0]   newv;

    assign idx      = r_idx[IW-1:0];
    assign cur_t    = (r_mat[idx] - r_now) ^ 32'h8000_0000;
    assign age      = r_now - r_mat[idx];
    assign matured  = !age[31];
    assign better   = !r_best_ok || cur_t < r_best_t ||
                      (cur_t == r_best_t && r_key[idx] < r_best_k);
    assign newv     = i_values_held ? r_req.value : 32'd0;
    assign expire   = r_now + {8'd0, r_req.delay};
    assign emit_go  = !r_out_v || i_res_take;
    assign scan_end = (r_idx == (IW+1)'(CAPACITY - 1));
    assign o_res_valid = r_out_v;
    assign o_res   = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_SCAN;
            ST_SCAN:  if (scan_end) begin
                n_state = (r_req.cmd == CMD_TICK) ? ST_EMIT : ST_APPLY;
            end
            ST_EMIT:  if (emit_go) n_state = r_best_ok ? ST_SCAN : ST_IDLE;
            ST_APPLY: if (emit_go) n_state = ST_REPLY;
            ST_REPLY: if (emit_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs: take strobe and next result register
    always_comb begin
        o_take  = (r_state == ST_IDLE) && i_valid;
        n_out_v = r_out_v && !i_res_take;
        n_out   = r_out;
        case (r_state)
            ST_EMIT: if (emit_go) begin
                if (r_best_ok) begin
                    n_out_v = i_notify;
                    n_out = '{KIND_MATURED, 1'b1, r_key[r_best_i],
                              i_values_held ? r_val[r_best_i] : 32'd0,
                              r_mat[r_best_i], r_count - 5'd1, 1'b0, 1'b0};
                end else begin
                    n_out_v = 1'b1;
                    n_out = '{KIND_REPLY, 1'b0, 32'd0, 32'd0, 32'd0,
                              r_count, 1'b0, 1'b1};
                end
            end
            ST_APPLY: if (emit_go) begin
                case (r_req.cmd)
                    CMD_INSERT, CMD_UPDATE: if (r_hit) begin
                        n_out_v = i_notify && i_values_held && r_val[r_hit_i] != newv;
                        n_out = '{KIND_REPLACE, 1'b1, r_req.key, r_val[r_hit_i],
                                  r_mat[r_hit_i], r_count, 1'b0, 1'b0};
                    end
                    CMD_REMOVE: if (r_hit) begin
                        n_out_v = i_notify;
                        n_out = '{KIND_REMOVED, 1'b1, r_req.key,
                                  i_values_held ? r_val[r_hit_i] : 32'd0,
                                  r_mat[r_hit_i], r_count - 5'd1, 1'b0, 1'b0};
                    end
                    default: ;
                endcase
            end
            ST_REPLY: if (emit_go) begin
                n_out_v = 1'b1;
                n_out = '{KIND_REPLY, 1'b0, r_req.key, 32'd0, 32'd0,
                          r_count, 1'b0, 1'b1};
                case (r_req.cmd)
                    CMD_INSERT: begin
                        if (r_hit || r_free_ok) begin
                            n_out.found  = r_hit;
                            n_out.value  = newv;
                            n_out.mature = expire;
                        end else begin
                            n_out.full = 1'b1;
                        end
                    end
                    CMD_UPDATE: if (r_hit) begin
                        n_out.found  = 1'b1;
                        n_out.value  = newv;
                        n_out.mature = expire;
                    end
                    CMD_REMOVE: n_out.found = r_hit;
                    CMD_LOOKUP: if (r_hit) begin
                        n_out.found  = 1'b1;
                        n_out.value  = i_values_held ? r_val[r_hit_i] : 32'd0;
                        n_out.mature = r_mat[r_hit_i];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_now   <= 32'd0;
            r_count <= 5'd0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_req <= i_req;
                    r_idx <= '0;
                    r_hit <= 1'b0; r_free_ok <= 1'b0; r_best_ok <= 1'b0;
                    if (i_req.cmd == CMD_TICK) r_now <= r_now + {8'd0, i_req.delay};
                end
                ST_SCAN: begin
                    if (r_valid[idx]) begin
                        if (r_key[idx] == r_req.key && !r_hit) begin
                            r_hit <= 1'b1; r_hit_i <= idx;
                        end
                        if (matured && better) begin
                            r_best_ok <= 1'b1; r_best_i <= idx;
                            r_best_t <= cur_t; r_best_k <= r_key[idx];
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok <= 1'b1; r_free_i <= idx;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                ST_EMIT: if (emit_go) begin
                    r_idx <= '0; r_best_ok <= 1'b0;
                    if (r_best_ok) begin
                        r_valid[r_best_i] <= 1'b0;
                        r_count <= r_count - 5'd1;
                    end
                end
                ST_APPLY: if (emit_go) begin
                    case (r_req.cmd)
                        CMD_INSERT, CMD_UPDATE: if (r_hit) begin
                            r_val[r_hit_i] <= newv;
                            r_mat[r_hit_i] <= expire;
                        end else if (r_req.cmd == CMD_INSERT && r_free_ok) begin
                            r_valid[r_free_i] <= 1'b1;
                            r_key[r_free_i] <= r_req.key;
                            r_val[r_free_i] <= newv;
                            r_mat[r_free_i] <= expire;
                            r_count <= r_count + 5'd1;
                        end
                        CMD_REMOVE: if (r_hit) begin
                            r_valid[r_hit_i] <= 1'b0;
                            r_count <= r_count - 5'd1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== design/expiring_key_value_table.sv =====
// ============================================================================
// expiring_key_value_table : keyed table with per-entry maturity
// Front request queue feeding a slot-scanning table engine.
// ============================================================================
// channel   | handshake      | payload
// request   | push / full    | command, entry_key, entry_value, delay_seconds
// result    | pop / empty    | kind .. last
// config    | APB write/read | values_held (0x0), notify_release (0x4)
//
// A command passes through intake, a scan of all CAPACITY slots, an apply
// step and a reply step. A tick passes through intake, then a full scan and
// an emit per matured entry and one more scan and emit for the reply. The slot
// scan over one engine sets the rate.
// Reset clears all valid bits. A stalled pop holds the engine at its next
// result; the two-deep front queue keeps accepting until it fills.
module expiring_key_value_table
    import ekv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_entry_key,
    input  logic [31:0] i_entry_value,
    input  logic [23:0] i_delay_seconds,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic        o_found,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_value,
    output logic [31:0] o_mature_time,
    output logic [4:0]  o_entry_count,
    output logic        o_table_full,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic r_values, r_notify;
    t_req req_in, req_q;
    logic q_valid, q_take, res_v;
    t_res res;

    assign pready = 1'b1;
    assign prdata = {31'd0, (paddr[2] == REG_NOTIFY) ? r_notify : r_values};

    // write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_values <= 1'b1;
            r_notify <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_VALUES) r_values <= pwdata[0];
            else r_notify <= pwdata[0];
        end
    end

    assign req_in = '{t_cmd'(i_command), i_entry_key, i_entry_value, i_delay_seconds};

    ekv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_req(req_in), .o_valid(q_valid), .o_req(req_q), .i_take(q_take)
    );

    ekv_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_values_held(r_values),
        .i_notify(r_notify), .i_valid(q_valid), .i_req(req_q), .o_take(q_take),
        .o_res_valid(res_v), .o_res(res), .i_res_take(pop && res_v)
    );

    assign empty         = !res_v;
    assign o_kind        = res.kind;
    assign o_found       = res.found;
    assign o_out_key     = res.key;
    assign o_out_value   = res.value;
    assign o_mature_time = res.mature;
    assign o_entry_count = res.count;
    assign o_table_full  = res.full;
    assign o_last        = res.last;

    // a result never reports an entry count above capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_entry_count <= 5'(CAPACITY)) else $error("count overflow");
    // a refused insert is always a final reply
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_table_full) |-> (o_last && o_kind == KIND_REPLY))
        else $error("full flag on notice");
    // a notice is never last and always reports found
    a_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_REPLY) |-> (!o_last && o_found))
        else $error("bad notice");
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Expiring key/value table testbench
// Drives table commands through the request queue, predicts every notice and
// reply with a local model of the table, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ekv_pkg::*;

    localparam int NSLOT     = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 20000;

    // Scoreboard: table model plus queue of expected results
    class table_scoreboard;
        bit          vals_on;
        bit          notify_on;
        bit          valid_q[NSLOT];
        logic [31:0] key_q[NSLOT];
        logic [31:0] val_q[NSLOT];
        logic [31:0] mat_q[NSLOT];
        logic [31:0] now_s;
        logic [4:0]  held;
        t_res        pending[$];
        int          errors;

        function void clear();
            vals_on = 1;
            notify_on = 1;
            foreach (valid_q[i]) valid_q[i] = 0;
            now_s = 0;
            held = 0;
            errors = 0;
        endfunction

        function void add(logic [1:0] kd, bit fnd, logic [31:0] k, logic [31:0] v,
                          logic [31:0] m, bit fl, bit lst);
            t_res r;
            r.kind = kd; r.found = fnd; r.key = k; r.value = vals_on ? v : 32'd0;
            r.mature = m; r.count = held; r.full = fl; r.last = lst;
            pending.push_back(r);
        endfunction

        // earliest matured slot, ties by key; -1 if none
        function int earliest_matured();
            int          best;
            logic [31:0] bt, t;
            best = -1;
            bt = 32'd0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!valid_q[i] || (now_s - mat_q[i]) >= 32'h8000_0000) continue;
                t = (mat_q[i] - now_s) ^ 32'h8000_0000;
                if (best < 0 || t < bt || (t == bt && key_q[i] < key_q[best])) begin
                    best = i;
                    bt = t;
                end
            end
            return best;
        endfunction

        function void note_request(t_req q);
            int          s;
            logic [31:0] nv, due;
            s = -1;
            nv = vals_on ? q.value : 32'd0;
            due = now_s + {8'd0, q.delay};
            if (q.cmd == CMD_TICK) begin
                now_s = now_s + {8'd0, q.delay};
                for (s = earliest_matured(); s >= 0; s = earliest_matured()) begin
                    valid_q[s] = 0;
                    held--;
                    if (notify_on)
                        add(KIND_MATURED, 1'b1, key_q[s], val_q[s], mat_q[s], 1'b0, 1'b0);
                end
                add(KIND_REPLY, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                return;
            end
            if (q.cmd > CMD_LOOKUP) begin
                add(KIND_REPLY, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                return;
            end
            for (int i = NSLOT - 1; i >= 0; i--)
                if (valid_q[i] && key_q[i] == q.key) s = i;
            case (q.cmd)
                CMD_INSERT, CMD_UPDATE: begin
                    if (s >= 0) begin
                        if (notify_on && vals_on && val_q[s] != nv)
                            add(KIND_REPLACE, 1'b1, q.key, val_q[s], mat_q[s], 1'b0, 1'b0);
                        val_q[s] = nv;
                        mat_q[s] = due;
                        add(KIND_REPLY, 1'b1, q.key, nv, due, 1'b0, 1'b1);
                    end else if (q.cmd == CMD_UPDATE) begin
                        add(KIND_REPLY, 1'b0, q.key, 32'd0, 32'd0, 1'b0, 1'b1);
                    end else begin
                        for (int i = NSLOT - 1; i >= 0; i--)
                            if (!valid_q[i]) s = i;
                        if (s < 0) begin
                            add(KIND_REPLY, 1'b0, q.key, 32'd0, 32'd0, 1'b1, 1'b1);
                        end else begin
                            valid_q[s] = 1; key_q[s] = q.key;
                            val_q[s] = nv; mat_q[s] = due;
                            held++;
                            add(KIND_REPLY, 1'b0, q.key, nv, due, 1'b0, 1'b1);
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (s >= 0) begin
                        valid_q[s] = 0;
                        held--;
                        if (notify_on)
                            add(KIND_REMOVED, 1'b1, q.key, val_q[s], mat_q[s], 1'b0, 1'b0);
                        add(KIND_REPLY, 1'b1, q.key, 32'd0, 32'd0, 1'b0, 1'b1);
                    end else begin
                        add(KIND_REPLY, 1'b0, q.key, 32'd0, 32'd0, 1'b0, 1'b1);
                    end
                end
                default: begin
                    if (s >= 0) add(KIND_REPLY, 1'b1, q.key, val_q[s], mat_q[s], 1'b0, 1'b1);
                    else add(KIND_REPLY, 1'b0, q.key, 32'd0, 32'd0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected %p", $time, want);
                $display("%0t:          actual   %p", $time, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        push, full, empty, pop;
    logic [2:0]  i_command;
    logic [31:0] i_entry_key, i_entry_value;
    logic [23:0] i_delay_seconds;
    logic [1:0]  o_kind;
    logic        o_found, o_table_full, o_last;
    logic [31:0] o_out_key, o_out_value, o_mature_time;
    logic [4:0]  o_entry_count;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    table_scoreboard sb;
    int  idle_cycles;
    int  n_sent, n_checked;
    int  pop_wait;
    bit  rx_enable;

    expiring_key_value_table i_dut (.*);

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // Send one request, honoring full
    task automatic send_request(t_cmd c, logic [31:0] k, logic [31:0] v, logic [23:0] d);
        t_req q;
        int   gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_command <= c; i_entry_key <= k; i_entry_value <= v; i_delay_seconds <= d;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        q.cmd = c; q.key = k; q.value = v; q.delay = d;
        sb.note_request(q);
        n_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, bit v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_VALUES) sb.vals_on = v;
        else sb.notify_on = v;
    endtask

    // Keys from a small pool so hits, replacements and full table occur
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom_range(0, 23);
        endcase
    endfunction

    task automatic random_phase(int count);
        int          w;
        t_cmd        c;
        logic [23:0] d;
        logic [31:0] v;
        for (int n = 0; n < count; n++) begin
            w = $urandom_range(0, 99);
            if (w < 40) c = CMD_INSERT;
            else if (w < 52) c = CMD_UPDATE;
            else if (w < 64) c = CMD_REMOVE;
            else if (w < 78) c = CMD_LOOKUP;
            else if (w < 96) c = CMD_TICK;
            else c = t_cmd'($urandom_range(5, 7));
            d = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 30));
            v = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
            send_request(c, pick_key(), v, d);
        end
    endtask

    // Result side: random wait before each pop, compare each accepted result
    always @(posedge i_clk) begin
        t_res got;
        if (!i_rst_n || !rx_enable) begin
            pop <= 1'b0;
            pop_wait = 0;
        end else begin
            if (pop && !empty) begin
                got.kind = o_kind; got.found = o_found; got.key = o_out_key;
                got.value = o_out_value; got.mature = o_mature_time;
                got.count = o_entry_count; got.full = o_table_full; got.last = o_last;
                sb.check_result(got);
                n_checked++;
                pop_wait = $urandom_range(0, 7);
            end else if (pop_wait > 0) begin
                pop_wait--;
            end
            pop <= (pop_wait == 0);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.clear();
        idle_cycles = 0; n_sent = 0; n_checked = 0; rx_enable = 0; pop_wait = 0;
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0;
        i_command = '0; i_entry_key = '0; i_entry_value = '0; i_delay_seconds = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_enable = 1;

        // directed: extremes, every command, replace, remove, maturity, bad codes
        send_request(CMD_LOOKUP, 32'd5, 32'd0, 24'd0);
        send_request(CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 24'd0);
        send_request(CMD_INSERT, 32'd7, 32'd1, 24'd3);
        send_request(CMD_INSERT, 32'd7, 32'd1, 24'd4);
        send_request(CMD_INSERT, 32'd7, 32'd2, 24'd3);
        send_request(CMD_INSERT, 32'd3, 32'd9, 24'd3);
        send_request(CMD_UPDATE, 32'd8, 32'd9, 24'd1);
        send_request(CMD_UPDATE, 32'd3, 32'hA5A5_5A5A, 24'd3);
        send_request(CMD_LOOKUP, 32'd7, 32'd0, 24'd0);
        send_request(CMD_TICK, 32'd0, 32'd0, 24'd3);
        send_request(CMD_REMOVE, 32'd0, 32'd0, 24'd0);
        send_request(CMD_REMOVE, 32'd0, 32'd0, 24'd0);
        send_request(CMD_BAD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(CMD_BAD6, 32'd1, 32'd1, 24'd1);
        send_request(CMD_BAD7, 32'd2, 32'd2, 24'd2);
        for (int k = 100; k < 116; k++) send_request(CMD_INSERT, k, k, 24'd2);
        send_request(CMD_TICK, 32'd0, 32'd0, 24'hFF_FFFF);

        // pause until the table has answered everything
        drain();
        random_phase(50);
        drain();

        // settings phases, extremes included
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_VALUES, p[0]);
            write_reg(REG_NOTIFY, p[1]);
            random_phase(50);
            drain();
        end
        write_reg(REG_VALUES, 1'b1);
        write_reg(REG_NOTIFY, 1'b1);
        random_phase(50);
        // flush what is left with long ticks
        for (int n = 0; n < 30; n++) send_request(CMD_TICK, 32'd0, 32'd0, 24'hFF_FFFF);
        drain();

        $display("sent %0d requests, checked %0d results over four register settings",
                 n_sent, n_checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ekv_pkg.sv
design/ekv_front.sv
design/ekv_back.sv
design/expiring_key_value_table.sv
tb/testbench.sv
